/* sv/lmot_pkg.sv */
`default_nettype none

package lmot_pkg;

    // Default width of the stored weights and biases (signed Q8.F, F = width - 8).
    localparam int WEIGHT_WIDTH_DEF = 32;

    // Learning-rate shift after reset.
    localparam logic [4:0] LEARNING_SHIFT_RESET = 5'd23;

    // Width of the right-shift amount handed to the multiply unit.
    localparam int MUL_SHIFT_W = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_ERR,
        ST_OUT
    } state_t;

    // One step per multiplication, in the order the sequencer runs them.
    typedef enum logic [4:0] {
        OP_H0A,
        OP_H0B,
        OP_H1A,
        OP_H1B,
        OP_YA,
        OP_YB,
        OP_HE0,
        OP_HE1,
        OP_V0,
        OP_V1,
        OP_HB0,
        OP_HB1,
        OP_W0,
        OP_W1,
        OP_W2,
        OP_W3,
        OP_OB
    } op_t;

    typedef struct packed {
        logic                   start;
        logic                   sat_weight;
        logic [MUL_SHIFT_W-1:0] shift;
    } mul_ctl_t;

endpackage

`default_nettype wire

/* sv/lmot_mul.sv */
`default_nettype none

// Multiply, floor shift and saturate. The first operand is taken 16 bits at a
// time, most significant digit first, through one 17 x BW multiplier.
module lmot_mul #(
    parameter int HW = 40,
    parameter int BW = 32,
    parameter int WW = 32
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire lmot_pkg::mul_ctl_t     ctl,
    input  wire logic signed [HW-1:0]   a,
    input  wire logic signed [BW-1:0]   b,
    output logic                        done,
    output logic signed [HW-1:0]        res
);

    localparam int ND = (HW + 15) / 16;
    localparam int DW = 16 * ND;
    localparam int PW = DW + BW;
    localparam int CW = $clog2(ND + 2);
    localparam logic [CW-1:0] CNT_PROD_END = CW'(ND);
    localparam logic [CW-1:0] CNT_FIN      = CW'(ND + 1);

    logic [DW-1:0]                      a_reg;
    logic signed [BW-1:0]               b_reg;
    logic [CW-1:0]                      cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic signed [BW+16:0]              prod_reg;
    logic signed [PW-1:0]               acc_reg;
    logic signed [HW-1:0]               res_reg;
    logic [lmot_pkg::MUL_SHIFT_W-1:0]   shift_reg;
    logic                               satw_reg;

    logic [15:0]                        digit;
    logic signed [16:0]                 digit_ext;
    logic signed [BW+16:0]              prod_next;
    logic signed [PW-1:0]               acc_next;
    logic signed [PW-1:0]               q;
    logic                               fits_h;
    logic                               fits_w;
    logic signed [HW-1:0]               res_next;

    assign digit = a_reg[DW-1 -: 16];

    // Only the top digit carries the sign; the lower ones are plain magnitudes.
    assign digit_ext = (cnt_reg == '0) ? {digit[15], digit} : {1'b0, digit};
    assign prod_next = digit_ext * b_reg;
    assign acc_next  = (acc_reg <<< 16) + PW'(prod_reg);

    assign q      = acc_reg >>> shift_reg;
    assign fits_h = (&q[PW-1:HW-1]) || (~|q[PW-1:HW-1]);
    assign fits_w = (&q[PW-1:WW-1]) || (~|q[PW-1:WW-1]);

    always_comb
    begin
        if (satw_reg)
        begin
            if (fits_w)
                res_next = HW'($signed(q[WW-1:0]));
            else if (q[PW-1])
                res_next = HW'($signed({1'b1, {(WW-1){1'b0}}}));
            else
                res_next = HW'($signed({1'b0, {(WW-1){1'b1}}}));
        end
        else
        begin
            if (fits_h)
                res_next = q[HW-1:0];
            else if (q[PW-1])
                res_next = {1'b1, {(HW-1){1'b0}}};
            else
                res_next = {1'b0, {(HW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_FIN)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg     <= DW'(a);
            b_reg     <= b;
            acc_reg   <= '0;
            shift_reg <= ctl.shift;
            satw_reg  <= ctl.sat_weight;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < CNT_PROD_END)
            begin
                prod_reg <= prod_next;
                a_reg    <= a_reg << 16;
            end
            if ((cnt_reg != '0) && (cnt_reg <= CNT_PROD_END))
                acc_reg <= acc_next;
            if (cnt_reg == CNT_FIN)
                res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

/* sv/linear_mlp_online_trainer_top.sv */
// Online trainer for a 2-2-1 linear network held in nine signed Q8.F registers.
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser: s_tuser selects
// infer (0) or infer-then-train (1), s_tdata carries two Q8.8 inputs and a
// Q16.16 target. Each input word gives one output word on m_tvalid/m_tready/
// m_tdata with the Q16.16 prediction and error (error is zero on infer).
// An infer word runs six multiplications and a train word all seventeen,
// one after another through a single multiply unit that walks its first
// operand in 16-bit digits, ND = ceil((WEIGHT_WIDTH + 8) / 16) of them.
// One word is worked on at a time: no new input word is taken before the
// output word of the last one is loaded; s_tready is high only between words.
// The output word sits in a register: a new input word is taken while it
// waits, and a finished word waits for the receiver before it is loaded.
// The user is to write the learning shift through cfg_wen/cfg_wdata between
// words; the block does not enforce this. It is sampled when a word is taken.
// Reset restores the initial weights and biases, a learning shift of 23,
// and empties the output register.
`default_nettype none

module linear_mlp_online_trainer_top #(
    parameter int WEIGHT_WIDTH = lmot_pkg::WEIGHT_WIDTH_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [63:0]  s_tdata,   // in_a [15:0], in_b [31:16], target [63:32]
    input  wire  [0:0]   s_tuser,   // operation [0]
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [63:0]  m_tdata,   // prediction [31:0], error [63:32]
    input  wire          cfg_wen,
    input  wire  [4:0]   cfg_wdata
);

    localparam int WW   = WEIGHT_WIDTH;
    localparam int FRAC = WW - 8;
    localparam int HW   = FRAC + 16;
    localparam int BW   = (WW > 32) ? WW : 32;
    localparam int SW   = HW + 2;
    localparam int MSW  = lmot_pkg::MUL_SHIFT_W;

    localparam logic [63:0] Q_01 = ((64'd1 << FRAC) + 64'd5) / 64'd10;
    localparam logic [63:0] Q_02 = ((64'd2 << FRAC) + 64'd5) / 64'd10;
    localparam logic [63:0] Q_03 = ((64'd3 << FRAC) + 64'd5) / 64'd10;
    localparam logic [63:0] Q_04 = ((64'd4 << FRAC) + 64'd5) / 64'd10;
    localparam logic [63:0] Q_05 = ((64'd5 << FRAC) + 64'd5) / 64'd10;
    localparam logic [63:0] Q_07 = ((64'd7 << FRAC) + 64'd5) / 64'd10;
    localparam logic [63:0] Q_08 = ((64'd8 << FRAC) + 64'd5) / 64'd10;

    localparam logic signed [BW-1:0] B_ONE = BW'(1);
    localparam logic signed [BW-1:0] B_OB  = BW'(1) << (FRAC - 16);
    localparam logic [MSW-1:0] SH_8    = MSW'(8);
    localparam logic [MSW-1:0] SH_16   = MSW'(16);
    localparam logic [MSW-1:0] SH_FRAC = MSW'(FRAC);

    lmot_pkg::state_t state_reg, state_next;
    lmot_pkg::op_t    op_reg, op_next;

    logic signed [WW-1:0] w_reg [4];
    logic signed [WW-1:0] v_reg [2];
    logic signed [WW-1:0] hb_reg [2];
    logic signed [WW-1:0] ob_reg;
    logic [4:0]           learning_shift_reg;

    logic signed [15:0]   x0_reg;
    logic signed [15:0]   x1_reg;
    logic signed [31:0]   tgt_reg;
    logic                 train_reg;
    logic [4:0]           s_reg;
    logic signed [SW-1:0] t_reg;
    logic signed [HW-1:0] h_reg [2];
    logic signed [HW-1:0] he_reg [2];
    logic signed [31:0]   pred_reg;
    logic signed [31:0]   err_reg;
    logic [63:0]          m_tdata_reg;
    logic                 m_tvalid_reg;

    lmot_pkg::mul_ctl_t   mul_ctl;
    logic                 mul_start;
    logic [MSW-1:0]       mul_shift;
    logic                 mul_satw;
    logic signed [HW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic                 mul_done;
    logic signed [HW-1:0] mul_res;

    logic                 in_take;
    logic                 out_load;
    logic                 wb_en;
    logic [MSW-1:0]       sh_s;
    logic signed [SW-1:0] sum_h;
    logic signed [HW-1:0] sum_h_clamped;
    logic signed [WW-1:0] bias_sel;
    logic signed [SW-1:0] t_init;
    logic signed [WW-1:0] wcur;
    logic signed [WW:0]   wsum;
    logic signed [WW-1:0] wnew;
    logic signed [32:0]   diff;
    logic signed [31:0]   err_next;

    function automatic logic signed [HW-1:0] clamp_h(input logic signed [SW-1:0] v);
        logic [2:0] top;
        top = v[SW-1:HW-1];
        if (top == 3'b000 || top == 3'b111)
            clamp_h = v[HW-1:0];
        else if (v[SW-1])
            clamp_h = {1'b1, {(HW-1){1'b0}}};
        else
            clamp_h = {1'b0, {(HW-1){1'b1}}};
    endfunction

    function automatic logic signed [WW-1:0] clamp_w(input logic signed [WW:0] v);
        if (v[WW] == v[WW-1])
            clamp_w = v[WW-1:0];
        else if (v[WW])
            clamp_w = {1'b1, {(WW-1){1'b0}}};
        else
            clamp_w = {1'b0, {(WW-1){1'b1}}};
    endfunction

    assign mul_ctl = '{start: mul_start, sat_weight: mul_satw, shift: mul_shift};

    lmot_mul #(
        .HW (HW),
        .BW (BW),
        .WW (WW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    assign in_take = s_tvalid && s_tready;
    assign sh_s    = MSW'(s_reg);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        wb_en      = 1'b0;
        mul_start  = 1'b0;
        unique case (state_reg)
            lmot_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = lmot_pkg::ST_MUL_START;
                    op_next    = lmot_pkg::OP_H0A;
                end
            end
            lmot_pkg::ST_MUL_START:
            begin
                mul_start  = 1'b1;
                state_next = lmot_pkg::ST_MUL_WAIT;
            end
            lmot_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    wb_en = 1'b1;
                    priority if (op_reg == lmot_pkg::OP_YB)
                        state_next = train_reg ? lmot_pkg::ST_ERR : lmot_pkg::ST_OUT;
                    else if (op_reg == lmot_pkg::OP_OB)
                        state_next = lmot_pkg::ST_OUT;
                    else
                    begin
                        op_next    = lmot_pkg::op_t'(op_reg + 5'd1);
                        state_next = lmot_pkg::ST_MUL_START;
                    end
                end
            end
            lmot_pkg::ST_ERR:
            begin
                op_next    = lmot_pkg::OP_HE0;
                state_next = lmot_pkg::ST_MUL_START;
            end
            lmot_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = lmot_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmot_pkg::ST_IDLE;
            end
        endcase
    end

    // Operand selection for the multiply unit.
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_shift = SH_8;
        mul_satw  = 1'b0;
        unique case (op_reg)
            lmot_pkg::OP_H0A:
            begin
                mul_a = HW'(x0_reg);
                mul_b = BW'(w_reg[0]);
            end
            lmot_pkg::OP_H0B:
            begin
                mul_a = HW'(x1_reg);
                mul_b = BW'(w_reg[2]);
            end
            lmot_pkg::OP_H1A:
            begin
                mul_a = HW'(x0_reg);
                mul_b = BW'(w_reg[1]);
            end
            lmot_pkg::OP_H1B:
            begin
                mul_a = HW'(x1_reg);
                mul_b = BW'(w_reg[3]);
            end
            lmot_pkg::OP_YA:
            begin
                mul_a     = h_reg[0];
                mul_b     = BW'(v_reg[0]);
                mul_shift = SH_FRAC;
            end
            lmot_pkg::OP_YB:
            begin
                mul_a     = h_reg[1];
                mul_b     = BW'(v_reg[1]);
                mul_shift = SH_FRAC;
            end
            lmot_pkg::OP_HE0:
            begin
                mul_a     = HW'(err_reg);
                mul_b     = BW'(v_reg[0]);
                mul_shift = SH_16;
            end
            lmot_pkg::OP_HE1:
            begin
                mul_a     = HW'(err_reg);
                mul_b     = BW'(v_reg[1]);
                mul_shift = SH_16;
            end
            lmot_pkg::OP_V0:
            begin
                mul_a     = h_reg[0];
                mul_b     = BW'(err_reg);
                mul_shift = SH_16 + sh_s;
                mul_satw  = 1'b1;
            end
            lmot_pkg::OP_V1:
            begin
                mul_a     = h_reg[1];
                mul_b     = BW'(err_reg);
                mul_shift = SH_16 + sh_s;
                mul_satw  = 1'b1;
            end
            lmot_pkg::OP_HB0:
            begin
                mul_a     = he_reg[0];
                mul_b     = B_ONE;
                mul_shift = sh_s;
                mul_satw  = 1'b1;
            end
            lmot_pkg::OP_HB1:
            begin
                mul_a     = he_reg[1];
                mul_b     = B_ONE;
                mul_shift = sh_s;
                mul_satw  = 1'b1;
            end
            lmot_pkg::OP_W0:
            begin
                mul_a     = he_reg[0];
                mul_b     = BW'(x0_reg);
                mul_shift = SH_8 + sh_s;
                mul_satw  = 1'b1;
            end
            lmot_pkg::OP_W1:
            begin
                mul_a     = he_reg[1];
                mul_b     = BW'(x0_reg);
                mul_shift = SH_8 + sh_s;
                mul_satw  = 1'b1;
            end
            lmot_pkg::OP_W2:
            begin
                mul_a     = he_reg[0];
                mul_b     = BW'(x1_reg);
                mul_shift = SH_8 + sh_s;
                mul_satw  = 1'b1;
            end
            lmot_pkg::OP_W3:
            begin
                mul_a     = he_reg[1];
                mul_b     = BW'(x1_reg);
                mul_shift = SH_8 + sh_s;
                mul_satw  = 1'b1;
            end
            lmot_pkg::OP_OB:
            begin
                mul_a     = HW'(err_reg);
                mul_b     = B_OB;
                mul_shift = sh_s;
                mul_satw  = 1'b1;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Write-back arithmetic: bias and partial sums, and the saturating weight updates.
    always_comb
    begin
        bias_sel = ob_reg;
        wcur     = ob_reg;
        unique case (op_reg)
            lmot_pkg::OP_H0A: bias_sel = hb_reg[0];
            lmot_pkg::OP_H1A: bias_sel = hb_reg[1];
            lmot_pkg::OP_V0:  wcur = v_reg[0];
            lmot_pkg::OP_V1:  wcur = v_reg[1];
            lmot_pkg::OP_HB0: wcur = hb_reg[0];
            lmot_pkg::OP_HB1: wcur = hb_reg[1];
            lmot_pkg::OP_W0:  wcur = w_reg[0];
            lmot_pkg::OP_W1:  wcur = w_reg[1];
            lmot_pkg::OP_W2:  wcur = w_reg[2];
            lmot_pkg::OP_W3:  wcur = w_reg[3];
            default:
            begin
                bias_sel = ob_reg;
                wcur     = ob_reg;
            end
        endcase
    end

    assign t_init        = SW'(mul_res) + SW'(bias_sel);
    assign sum_h         = t_reg + SW'(mul_res);
    assign sum_h_clamped = clamp_h(sum_h);
    assign wsum          = (WW+1)'(wcur) + (WW+1)'($signed(mul_res[WW-1:0]));
    assign wnew          = clamp_w(wsum);

    assign diff = 33'(tgt_reg) - 33'(pred_reg);
    assign err_next = (diff[32] == diff[31]) ? diff[31:0]
                    : (diff[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}});

    // Control registers and the stored network.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= lmot_pkg::ST_IDLE;
            op_reg             <= lmot_pkg::OP_H0A;
            m_tvalid_reg       <= 1'b0;
            learning_shift_reg <= lmot_pkg::LEARNING_SHIFT_RESET;
            w_reg[0]  <= Q_02[WW-1:0];
            w_reg[1]  <= Q_05[WW-1:0];
            w_reg[2]  <= Q_03[WW-1:0];
            w_reg[3]  <= Q_08[WW-1:0];
            v_reg[0]  <= Q_04[WW-1:0];
            v_reg[1]  <= Q_07[WW-1:0];
            hb_reg[0] <= Q_01[WW-1:0];
            hb_reg[1] <= Q_01[WW-1:0];
            ob_reg    <= Q_01[WW-1:0];
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_wen)
                learning_shift_reg <= cfg_wdata;
            if (wb_en)
            begin
                unique case (op_reg)
                    lmot_pkg::OP_V0:  v_reg[0]  <= wnew;
                    lmot_pkg::OP_V1:  v_reg[1]  <= wnew;
                    lmot_pkg::OP_HB0: hb_reg[0] <= wnew;
                    lmot_pkg::OP_HB1: hb_reg[1] <= wnew;
                    lmot_pkg::OP_W0:  w_reg[0]  <= wnew;
                    lmot_pkg::OP_W1:  w_reg[1]  <= wnew;
                    lmot_pkg::OP_W2:  w_reg[2]  <= wnew;
                    lmot_pkg::OP_W3:  w_reg[3]  <= wnew;
                    lmot_pkg::OP_OB:  ob_reg    <= wnew;
                    default:
                    begin
                        ob_reg <= ob_reg;
                    end
                endcase
            end
        end
    end

    // Per-word working values.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x0_reg    <= $signed(s_tdata[15:0]);
            x1_reg    <= $signed(s_tdata[31:16]);
            tgt_reg   <= $signed(s_tdata[63:32]);
            train_reg <= s_tuser[0];
            s_reg     <= learning_shift_reg;
        end
        if (state_reg == lmot_pkg::ST_ERR)
            err_reg <= err_next;
        if (out_load)
            m_tdata_reg <= {err_reg, pred_reg};
        if (wb_en)
        begin
            unique case (op_reg)
                lmot_pkg::OP_H0A: t_reg <= t_init;
                lmot_pkg::OP_H0B: h_reg[0] <= sum_h_clamped;
                lmot_pkg::OP_H1A: t_reg <= t_init;
                lmot_pkg::OP_H1B: h_reg[1] <= sum_h_clamped;
                lmot_pkg::OP_YA:  t_reg <= t_init;
                lmot_pkg::OP_YB:
                begin
                    // Floor to Q16.16 is a plain slice of the Q16.F output.
                    pred_reg <= sum_h_clamped[HW-1:FRAC-16];
                    if (!train_reg)
                        err_reg <= '0;
                end
                lmot_pkg::OP_HE0: he_reg[0] <= mul_res;
                lmot_pkg::OP_HE1: he_reg[1] <= mul_res;
                default:
                begin
                    t_reg <= t_reg;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* sv/lmot_checker.sv */
`default_nettype none

module lmot_checker (
    input wire         clk,
    input wire         rst_n,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire  [0:0]  s_tuser,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire  [63:0] m_tdata
);

    // Operation of the most recently accepted input word.
    logic last_train_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_train_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            last_train_reg <= s_tuser[0];
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed or vanished while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again straight after a word was accepted");

    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("output word appeared without a word being worked on");

    a_infer_zero_error: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) && !last_train_reg |-> m_tdata[63:32] == 32'd0)
        else $error("infer word returned a non-zero error");

endmodule

bind linear_mlp_online_trainer_top lmot_checker u_lmot_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/mlp_trainer_checker.sv */
`timescale 1ns / 1ps

module mlp_trainer_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [63:0] s_tdata,   // in_a [15:0], in_b [31:16], target [63:32]
    input  wire  [0:0]  s_tuser,   // operation [0]
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [63:0] m_tdata,   // prediction [31:0], error [63:32]
    input  wire         cfg_wen,
    input  wire  [4:0]  cfg_wdata,
    output int          failures,
    output int          outstanding
);

    localparam int     FRAC    = lmot_pkg::WEIGHT_WIDTH_DEF - 8;
    localparam longint W_LIM   = (64'sd1 <<< (lmot_pkg::WEIGHT_WIDTH_DEF - 1)) - 1;
    localparam longint H_LIM   = (64'sd1 <<< (FRAC + 15)) - 1;
    localparam longint Q32_LIM = 64'sd2147483647;

    typedef struct packed {
        logic [31:0] error;
        logic [31:0] prediction;
    } net_word_t;

    longint     ih_w [4];
    longint     ho_w [2];
    longint     h_b [2];
    longint     o_b;
    logic [4:0] lr_shift;

    net_word_t  predicted_words [$];
    net_word_t  seen_word;
    net_word_t  due_word;

    function automatic longint sat(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim - 1)
            return -lim - 1;
        return v;
    endfunction

    // Product scaled down by 2^sh, rounded towards minus infinity, then saturated.
    function automatic longint mul_floor(longint a, longint b, int unsigned sh, longint lim);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] wide;
        wa = a;
        wb = b;
        wide = (wa * wb) >>> sh;
        if (wide > lim)
            return lim;
        if (wide < -lim - 1)
            return -lim - 1;
        return longint'(wide);
    endfunction

    function automatic longint tenths(int t);
        return ((longint'(t) <<< FRAC) + 5) / 10;
    endfunction

    // Forward pass and, on a training word, one gradient step on the stored network.
    function automatic net_word_t run_network(logic train, logic [63:0] data);
        longint      x [2];
        longint      h [2];
        longint      he [2];
        longint      dv [2];
        longint      dhb [2];
        longint      dw [4];
        longint      yq;
        longint      pred;
        longint      err;
        longint      dob;
        int unsigned s;
        net_word_t   res;
        x[0] = $signed(data[15:0]);
        x[1] = $signed(data[31:16]);
        s = lr_shift;
        err = 0;
        for (int j = 0; j < 2; j++)
        begin
            h[j] = sat(mul_floor(x[0], ih_w[j], 8, H_LIM)
                     + mul_floor(x[1], ih_w[2 + j], 8, H_LIM) + h_b[j], H_LIM);
        end
        yq = sat(mul_floor(h[0], ho_w[0], FRAC, H_LIM)
               + mul_floor(h[1], ho_w[1], FRAC, H_LIM) + o_b, H_LIM);
        pred = mul_floor(yq, 1, FRAC - 16, Q32_LIM);
        if (train)
        begin
            err = sat(longint'($signed(data[63:32])) - pred, Q32_LIM);
            for (int j = 0; j < 2; j++)
                he[j] = mul_floor(err, ho_w[j], 16, H_LIM);
            for (int j = 0; j < 2; j++)
            begin
                dv[j]  = mul_floor(h[j], err, 16 + s, W_LIM);
                dhb[j] = mul_floor(he[j], 1, s, W_LIM);
                for (int i = 0; i < 2; i++)
                    dw[2 * i + j] = mul_floor(he[j], x[i], 8 + s, W_LIM);
            end
            dob = mul_floor(err, 64'sd1 <<< (FRAC - 16), s, W_LIM);
            // Every delta comes from the old values, so the updates go in only now.
            for (int j = 0; j < 2; j++)
            begin
                ho_w[j] = sat(ho_w[j] + dv[j], W_LIM);
                h_b[j]  = sat(h_b[j] + dhb[j], W_LIM);
            end
            for (int i = 0; i < 4; i++)
                ih_w[i] = sat(ih_w[i] + dw[i], W_LIM);
            o_b = sat(o_b + dob, W_LIM);
        end
        res.prediction = pred[31:0];
        res.error      = err[31:0];
        return res;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        failures++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ih_w[0] = tenths(2);
            ih_w[1] = tenths(5);
            ih_w[2] = tenths(3);
            ih_w[3] = tenths(8);
            ho_w[0] = tenths(4);
            ho_w[1] = tenths(7);
            h_b[0]  = tenths(1);
            h_b[1]  = tenths(1);
            o_b     = tenths(1);
            lr_shift = lmot_pkg::LEARNING_SHIFT_RESET;
            predicted_words.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wen)
                lr_shift = cfg_wdata;
            if (s_tvalid && s_tready)
                predicted_words.insert(predicted_words.size(),
                                       run_network(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready)
            begin
                seen_word = m_tdata;
                if (predicted_words.size() == 0)
                begin
                    report("unexpected output word", 32'h0, seen_word.prediction);
                end
                else
                begin
                    due_word = predicted_words.pop_front();
                    if (seen_word.prediction !== due_word.prediction)
                        report("prediction", due_word.prediction, seen_word.prediction);
                    if (seen_word.error !== due_word.error)
                        report("error", due_word.error, seen_word.error);
                end
            end
            outstanding <= predicted_words.size();
        end
    end

endmodule

/* tb/tb_linear_mlp_online_trainer_top.sv */
`timescale 1ns / 1ps

module tb_linear_mlp_online_trainer_top;

    localparam int CYCLE_LIMIT  = 900000;
    localparam int SETTLE_CYCLES = 130;
    localparam int PHASE_WORDS  = 250;
    localparam int NUM_PHASES   = 6;
    localparam logic INFER = 1'b0;
    localparam logic TRAIN = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [63:0] s_tdata = '0;    // in_a [15:0], in_b [31:16], target [63:32]
    logic [0:0]  s_tuser = '0;    // operation [0]
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [63:0] m_tdata;         // prediction [31:0], error [63:32]
    logic        cfg_wen = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    int failures;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    logic [4:0] phase_shift [NUM_PHASES];

    linear_mlp_online_trainer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    mlp_trainer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver side: ready stays high except for random stall bursts.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_word(logic op, logic [15:0] a, logic [15:0] b, logic [31:0] tgt);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tgt, b, a};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_shift(logic [4:0] value);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // Mostly small inputs around unity, now and then anything in range.
    function automatic logic [15:0] pick_input();
        if ($urandom_range(0, 9) < 2)
            return 16'($urandom());
        return 16'($urandom_range(0, 1023)) - 16'd512;
    endfunction

    function automatic logic [31:0] pick_target();
        case ($urandom_range(0, 19))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        endcase
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes and simple values of the inputs and targets; the target must be ignored on infer.
        send_word(INFER, 16'h0000, 16'h0000, 32'h0000_0000);
        send_word(INFER, 16'h7fff, 16'h7fff, 32'h7fff_ffff);
        send_word(INFER, 16'h8000, 16'h8000, 32'h8000_0000);
        send_word(INFER, 16'h7fff, 16'h8000, 32'h1234_5678);
        send_word(TRAIN, 16'h0100, 16'h0100, 32'h0001_0000);
        send_word(TRAIN, 16'h0080, 16'hff80, 32'h0000_0000);
        send_word(TRAIN, 16'h7fff, 16'h7fff, 32'h7fff_ffff);
        send_word(TRAIN, 16'h8000, 16'h8000, 32'h8000_0000);
        send_word(TRAIN, 16'h0000, 16'h0000, 32'h7fff_ffff);
        send_word(TRAIN, 16'h0000, 16'h0000, 32'h8000_0000);

        // A learning rate of one drives the stored values into saturation.
        write_shift(5'd0);
        send_word(TRAIN, 16'h7fff, 16'h8000, 32'h7fff_ffff);
        send_word(TRAIN, 16'h8000, 16'h7fff, 32'h8000_0000);
        send_word(TRAIN, 16'h0100, 16'h0100, 32'h0000_0000);
        send_word(INFER, 16'h0100, 16'h0100, 32'h0000_0000);

        write_shift(5'd31);
        send_word(TRAIN, 16'h0100, 16'h0200, 32'h0005_0000);
        send_word(TRAIN, 16'h7fff, 16'h7fff, 32'h8000_0000);
        send_word(INFER, 16'h7fff, 16'h7fff, 32'h0000_0000);

        phase_shift[0] = 5'd18;
        phase_shift[1] = 5'd31;
        phase_shift[2] = 5'($urandom_range(8, 20));
        phase_shift[3] = 5'd12;
        phase_shift[4] = 5'd0;
        phase_shift[5] = 5'd23;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_shift(phase_shift[p]);
            if (p == NUM_PHASES - 1)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
                recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
            end
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Hold the sender back once until the network has answered everything.
                if (p == 2 && n == PHASE_WORDS / 2)
                    wait_drained();
                send_word(($urandom_range(0, 9) < 6) ? TRAIN : INFER,
                          pick_input(), pick_input(), pick_target());
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
